// ===== sv/purst_pkg.sv =====
// ----------------------------------------------------------------------------
// purst_pkg
// Shared types and constants for the point-update range-sum tree.
// ----------------------------------------------------------------------------
package purst_pkg;

    localparam int LEAVES = 64;                   // leaf count, power of two
    localparam int DEPTH  = 2 * LEAVES;           // node store entries, entry 0 unused
    localparam int ADDR_W = $clog2(DEPTH);        // node index width
    localparam int WIN_W  = ADDR_W + 1;           // query window bound, reaches DEPTH
    localparam int POS_W  = 7;
    localparam int AMT_W  = 16;
    localparam int SUM_W  = 32;
    localparam int ACT_W  = 2;
    localparam int S_DATA_W = 40;                 // 37 field bits padded to bytes

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_SUB   = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_QRY_LEFT,
        ST_QRY_RIGHT,
        ST_QRY_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the incoming item
        logic upd_rd;     // read the current node
        logic upd_wr;     // write the current node, read its parent, climb
        logic q_left;     // left window step
        logic q_right;    // right window step, then both bounds go up a level
        logic out_load;   // move the sum into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pos_ok;     // incoming position is inside 1..LEAVES
        logic at_root;    // current node is the root
        logic win_open;   // left bound below right bound
        logic out_free;   // output register can take a new sum
    } sts_t;

endpackage

// ===== sv/purst_ram.sv =====
// ----------------------------------------------------------------------------
// purst_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module purst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/purst_ctrl.sv =====
// ----------------------------------------------------------------------------
// purst_ctrl
// Sequencer for tree updates and range queries.
// ----------------------------------------------------------------------------
module purst_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic [purst_pkg::ACT_W-1:0]      action,
    input  purst_pkg::sts_t                  sts,
    output logic                             s_tready,
    output purst_pkg::cmd_t                  cmd
);

    purst_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            purst_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (purst_pkg::action_t'(action)) inside
                        purst_pkg::ACT_ADD, purst_pkg::ACT_SUB: begin
                            if (sts.pos_ok) state_next = purst_pkg::ST_UPD_RD;
                        end
                        purst_pkg::ACT_QUERY: state_next = purst_pkg::ST_QRY_LEFT;
                        default: state_next = purst_pkg::ST_IDLE;
                    endcase
                end
            end
            purst_pkg::ST_UPD_RD: state_next = purst_pkg::ST_UPD_WR;
            purst_pkg::ST_UPD_WR: begin
                if (sts.at_root) state_next = purst_pkg::ST_IDLE;
            end
            purst_pkg::ST_QRY_LEFT: begin
                state_next = sts.win_open ? purst_pkg::ST_QRY_RIGHT : purst_pkg::ST_QRY_DONE;
            end
            purst_pkg::ST_QRY_RIGHT: state_next = purst_pkg::ST_QRY_LEFT;
            purst_pkg::ST_QRY_DONE: begin
                if (sts.out_free) state_next = purst_pkg::ST_IDLE;
            end
            default: state_next = purst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == purst_pkg::ST_IDLE);
        cmd          = '0;
        cmd.load     = (state_reg == purst_pkg::ST_IDLE) && s_tvalid;
        cmd.upd_rd   = (state_reg == purst_pkg::ST_UPD_RD);
        cmd.upd_wr   = (state_reg == purst_pkg::ST_UPD_WR);
        cmd.q_left   = (state_reg == purst_pkg::ST_QRY_LEFT) && sts.win_open;
        cmd.q_right  = (state_reg == purst_pkg::ST_QRY_RIGHT);
        cmd.out_load = (state_reg == purst_pkg::ST_QRY_DONE) && sts.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= purst_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/purst_dp.sv =====
// ----------------------------------------------------------------------------
// purst_dp
// Node store, update path, query window and sum accumulator.
// ----------------------------------------------------------------------------
module purst_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [purst_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic [purst_pkg::ACT_W-1:0]         s_tuser,
    input  purst_pkg::cmd_t                     cmd,
    output purst_pkg::sts_t                     sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [purst_pkg::SUM_W-1:0]         m_tdata
);

    localparam int ADDR_W = purst_pkg::ADDR_W;
    localparam int WIN_W  = purst_pkg::WIN_W;
    localparam int SUM_W  = purst_pkg::SUM_W;
    localparam int POS_W  = purst_pkg::POS_W;

    // item fields
    logic [POS_W-1:0]           in_pos, in_lo, in_hi;
    logic [purst_pkg::AMT_W-1:0] in_amt;
    int                         lo_c, hi_c;

    logic [ADDR_W-1:0] node_reg, node_next;
    logic [WIN_W-1:0]  left_reg, left_next;
    logic [WIN_W-1:0]  right_reg, right_next;
    logic [SUM_W-1:0]  amt_reg, amt_next;
    logic              sub_reg, sub_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic              pend_reg, pend_next;
    logic [purst_pkg::DEPTH-1:0] vld_reg;
    logic              vldq_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [SUM_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [ADDR_W-1:0] rd_addr;
    logic [SUM_W-1:0]  rd_data, rd_val, wr_data;
    logic              left_odd, right_odd;

    assign in_pos = s_tdata[6:0];
    assign in_amt = s_tdata[22:7];
    assign in_lo  = s_tdata[29:23];
    assign in_hi  = s_tdata[36:30];

    assign lo_c = (in_lo == '0) ? 1 : int'(in_lo);
    assign hi_c = (int'(in_hi) > purst_pkg::LEAVES) ? purst_pkg::LEAVES : int'(in_hi);

    assign left_odd  = left_reg[0];
    assign right_odd = right_reg[0];

    // never-written nodes read as zero
    assign rd_val  = vldq_reg ? rd_data : '0;
    assign wr_data = sub_reg ? (rd_val - amt_reg) : (rd_val + amt_reg);

    always_comb begin
        rd_addr = node_reg;
        if (cmd.upd_wr) begin
            rd_addr = node_reg >> 1;
        end else if (cmd.q_left) begin
            rd_addr = left_reg[ADDR_W-1:0];
        end else if (cmd.q_right) begin
            rd_addr = ADDR_W'(right_reg - WIN_W'(1));
        end
    end

    purst_ram #(
        .WIDTH (SUM_W),
        .DEPTH (purst_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.upd_wr),
        .waddr (node_reg),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        node_next     = node_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        amt_next      = amt_reg;
        sub_next      = sub_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        pend_next = (cmd.q_left && left_odd) || (cmd.q_right && right_odd);
        if (pend_reg) acc_next = acc_reg + rd_val;

        if (cmd.load) begin
            node_next  = ADDR_W'(purst_pkg::LEAVES - 1 + int'(in_pos));
            left_next  = WIN_W'(purst_pkg::LEAVES - 1 + lo_c);
            right_next = WIN_W'(purst_pkg::LEAVES + hi_c);
            amt_next   = SUM_W'(in_amt);
            sub_next   = (s_tuser == purst_pkg::ACT_SUB);
            acc_next   = '0;
        end
        if (cmd.upd_wr) node_next = node_reg >> 1;
        if (cmd.q_left && left_odd) left_next = left_reg + WIN_W'(1);
        if (cmd.q_right) begin
            left_next  = left_reg >> 1;
            right_next = right_odd ? ((right_reg - WIN_W'(1)) >> 1) : (right_reg >> 1);
        end

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            vld_reg      <= '0;
            vldq_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg     <= pend_next;
            vldq_reg     <= vld_reg[rd_addr];
            if (cmd.upd_wr) vld_reg[node_reg] <= 1'b1;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        amt_reg     <= amt_next;
        sub_reg     <= sub_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        sts          = '0;
        sts.pos_ok   = (in_pos != '0) && (int'(in_pos) <= purst_pkg::LEAVES);
        sts.at_root  = (node_reg == ADDR_W'(1));
        sts.win_open = (left_reg < right_reg);
        sts.out_free = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/point_update_range_sum_tree.sv =====
// ----------------------------------------------------------------------------
// point_update_range_sum_tree
// Segment tree over 64 leaves: point add/subtract, inclusive range-sum query.
// ----------------------------------------------------------------------------
// Add/subtract: one read, then one read-modify-write per node from leaf to root
//   (single-port-read node RAM).
// Query: a left step and a right step per tree level walked (one RAM read each
//   side); the sum shows on m_tvalid the cycle after the finish step loads it.
// Throughput: one item at a time; a query whose sum finds the output register
//   still full waits in its finish step, and the input stalls until it drains.
// Reset: per-node valid bits clear at once, so the tree reads all zero; no sweep.
// ----------------------------------------------------------------------------
module point_update_range_sum_tree (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [6:0] position, [22:7] amount, [29:23] range_low, [36:30] range_high,
    // [39:37] zero
    input  logic [purst_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] action
    input  logic [purst_pkg::ACT_W-1:0]      s_tuser,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] range_sum
    output logic [purst_pkg::SUM_W-1:0]      m_tdata
);

    purst_pkg::cmd_t cmd;
    purst_pkg::sts_t sts;

    // sequencer: decides the walk, one memory step per state
    purst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // node RAM, window bounds, accumulator and output register
    purst_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // an accepted query keeps the input side busy next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == purst_pkg::ACT_QUERY) |=> !s_tready)
        else $error("input ready right after a query was accepted");

    // a new sum only lands when the output register is free
    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("sum loaded over an untaken result");

    // every result comes from the query finish step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result raised without a finished query");

endmodule
